[design/pbsd_pkg.sv]
// ----------------------------------------------------------------------------
// pbsd_pkg
// Types and constants shared by the BAR size decoder and its interfaces.
// ----------------------------------------------------------------------------
package pbsd_pkg;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_IO   = 2'd1,
		KIND_MEM  = 2'd2,
		KIND_ROM  = 2'd3
	} kind_t;

	localparam logic [31:0] ALL_ONES32    = 32'hffff_ffff;
	localparam logic [31:0] IO_ADDR_MASK  = 32'hffff_fffc;
	localparam logic [31:0] MEM_ADDR_MASK = 32'hffff_fff0;
	localparam logic [31:0] ROM_ADDR_MASK = 32'hffff_f800;
	localparam logic [1:0]  MEM_TYPE_64   = 2'b10;

	typedef struct packed {
		logic        rom_probe;
		logic [31:0] orig_low;
		logic [31:0] size_low;
		logic [31:0] orig_high;
		logic [31:0] size_high;
	} probe_t;

	typedef struct packed {
		kind_t       resource_kind;
		logic [3:0]  low_bits;
		logic        prefetchable;
		logic        is_64bit;
		logic        rom_enabled;
		logic        unset;
		logic        disabled;
		logic [63:0] region_start;
		logic [63:0] region_end;
	} result_t;

endpackage

[design/pbsd_ifs.sv]
// ----------------------------------------------------------------------------
// pbsd_ifs
// Valid/ready channels for probe requests, decoded results and configuration.
// ----------------------------------------------------------------------------
interface pbsd_probe_if;
	logic            valid;
	logic            ready;
	pbsd_pkg::probe_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pbsd_result_if;
	logic             valid;
	logic             ready;
	pbsd_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pbsd_cfg_if;
	logic valid;
	logic ready;
	logic data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/pci_bar_size_decoder.sv]
// ----------------------------------------------------------------------------
// pci_bar_size_decoder
// Decodes one probed PCI base address register into type flags and a region.
// ----------------------------------------------------------------------------
// Each request on the probe channel carries the original and all-ones readback
// words of one BAR. The result channel returns exactly one decoded result per
// request, in order. The cfg channel writes the wide_addresses register; it is
// always ready and should only be written while no request is in flight.
// Each accepted request reaches the result channel through the three register
// stages: classify and mask, lowest set bit and sizability check, then the
// 64-bit end address add. One request is accepted every cycle while the
// receiver is ready.
// Reset clears all stage valid bits and sets wide_addresses to 1.
// When the receiver stalls, the result is held and each stage holding a
// request stops; empty stages still advance, so bubbles close up and the probe
// channel drops ready only once all three stages are full.
// ----------------------------------------------------------------------------
module pci_bar_size_decoder (
	input logic clk,
	input logic arst_n,
	pbsd_probe_if.sink probe,
	pbsd_result_if.source result,
	pbsd_cfg_if.sink cfg
);

	logic wide_q;

	logic valid_s1, valid_s2, valid_s3;
	logic en_s1, en_s2, en_s3;

	pbsd_pkg::kind_t kind_s1;
	logic [3:0]      bits_s1;
	logic            pref_s1, wide_s1, romen_s1, hi_nz_s1, narrow_s1;
	logic [63:0]     base_s1, rb_s1, mask_s1;

	pbsd_pkg::kind_t kind_s2;
	logic [3:0]      bits_s2;
	logic            pref_s2, wide_s2, romen_s2, hi_nz_s2, narrow_s2, bad_s2;
	logic [63:0]     base_s2, size_s2, below_s2;

	pbsd_pkg::result_t res_s3;

	// Stage 1 combinational decode.
	logic [31:0]     lo_c, szlo_c, mask32_c;
	pbsd_pkg::kind_t kind_c;
	logic [3:0]      bits_c;
	logic            pref_c, wide_c, romen_c;
	logic [63:0]     base_c, rb_c, mask_c;

	// Stage 2 combinational sizing.
	logic [63:0] dec_c, lowest_c, below_c;
	logic        fill_ok_c;

	// Stage 3 combinational result.
	logic [63:0]       end_c;
	logic              too_large_c;
	pbsd_pkg::result_t res_c;

	assign en_s3 = !valid_s3 || result.ready;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;

	assign probe.ready  = en_s1;
	assign cfg.ready    = 1'b1;
	assign result.valid = valid_s3;
	assign result.data  = res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= 1'b1;
		end else if (cfg.valid) begin
			wide_q <= cfg.data;
		end
	end

	always_comb begin
		lo_c   = (probe.data.orig_low == pbsd_pkg::ALL_ONES32) ? '0 : probe.data.orig_low;
		szlo_c = (probe.data.size_low == pbsd_pkg::ALL_ONES32) ? '0 : probe.data.size_low;
		bits_c  = '0;
		pref_c  = 1'b0;
		wide_c  = 1'b0;
		romen_c = 1'b0;
		priority if (probe.data.rom_probe) begin
			kind_c   = pbsd_pkg::KIND_ROM;
			romen_c  = lo_c[0];
			mask32_c = pbsd_pkg::ROM_ADDR_MASK;
		end else if (lo_c[0]) begin
			kind_c   = pbsd_pkg::KIND_IO;
			bits_c   = {2'b00, lo_c[1:0]};
			mask32_c = pbsd_pkg::IO_ADDR_MASK;
		end else begin
			kind_c   = pbsd_pkg::KIND_MEM;
			bits_c   = lo_c[3:0];
			pref_c   = lo_c[3];
			wide_c   = (lo_c[2:1] == pbsd_pkg::MEM_TYPE_64);
			mask32_c = pbsd_pkg::MEM_ADDR_MASK;
		end
		base_c = {wide_c ? probe.data.orig_high : 32'h0, lo_c & mask32_c};
		rb_c   = {wide_c ? probe.data.size_high : 32'h0, szlo_c & mask32_c};
		mask_c = {wide_c ? pbsd_pkg::ALL_ONES32 : 32'h0, mask32_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= probe.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			kind_s1   <= kind_c;
			bits_s1   <= bits_c;
			pref_s1   <= pref_c;
			wide_s1   <= wide_c;
			romen_s1  <= romen_c;
			hi_nz_s1  <= (probe.data.orig_high != 32'h0);
			narrow_s1 <= !wide_q;
			base_s1   <= base_c;
			rb_s1     <= rb_c;
			mask_s1   <= mask_c;
		end
	end

	always_comb begin
		dec_c     = rb_s1 - 64'd1;
		lowest_c  = rb_s1 & ~dec_c;
		below_c   = ~rb_s1 & dec_c;
		fill_ok_c = ((base_s1 | below_c) & mask_s1) == mask_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			kind_s2   <= kind_s1;
			bits_s2   <= bits_s1;
			pref_s2   <= pref_s1;
			wide_s2   <= wide_s1;
			romen_s2  <= romen_s1;
			hi_nz_s2  <= hi_nz_s1;
			narrow_s2 <= narrow_s1;
			base_s2   <= base_s1;
			size_s2   <= lowest_c;
			below_s2  <= below_c;
			bad_s2    <= (rb_s1 == 64'h0) || ((base_s1 == rb_s1) && !fill_ok_c);
		end
	end

	always_comb begin
		end_c       = base_s2 + below_s2;
		// The size is a single set bit, so anything above bit 32 exceeds 4 GB.
		too_large_c = |size_s2[63:33];
		res_c.resource_kind = kind_s2;
		res_c.low_bits      = bits_s2;
		res_c.prefetchable  = pref_s2;
		res_c.is_64bit      = wide_s2;
		res_c.rom_enabled   = romen_s2;
		res_c.unset         = 1'b0;
		res_c.disabled      = 1'b0;
		priority if (bad_s2) begin
			res_c = '0;
		end else if (wide_s2 && narrow_s2 && too_large_c) begin
			res_c.unset        = 1'b1;
			res_c.disabled     = 1'b1;
			res_c.region_start = '0;
			res_c.region_end   = '0;
		end else if (wide_s2 && narrow_s2 && hi_nz_s2) begin
			res_c.unset        = 1'b1;
			res_c.region_start = '0;
			res_c.region_end   = below_s2;
		end else begin
			res_c.region_start = base_s2;
			res_c.region_end   = end_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			res_s3 <= res_c;
		end
	end

	// A disabled region is always also marked for reallocation.
	a_disabled_unset: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && res_s3.disabled |-> res_s3.unset)
		else $error("disabled result without unset");

	// A rejected BAR reports no region.
	a_none_empty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && res_s3.resource_kind == pbsd_pkg::KIND_NONE |->
		res_s3.region_start == 64'h0 && res_s3.region_end == 64'h0 && !res_s3.unset)
		else $error("rejected BAR with nonzero result fields");

	// Type flags belong to the matching kind only.
	a_flag_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && (res_s3.is_64bit || res_s3.prefetchable) |->
		res_s3.resource_kind == pbsd_pkg::KIND_MEM)
		else $error("memory flags on a non-memory result");

	// An accepted request always lands in the first stage.
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		probe.valid && probe.ready |=> valid_s1)
		else $error("accepted request lost at stage one");

endmodule

[bench/tb_pci_bar_size_decoder.sv]
// ----------------------------------------------------------------------------
// tb_pci_bar_size_decoder
// Self-checking bench for the PCI BAR size decoder.
// ----------------------------------------------------------------------------
// Probe requests come from a queue that the stimulus process fills. It starts
// with hand-picked BARs and then sends random, mostly well-formed ones. The
// decoder is predicted in the bench when each request is accepted, and every
// result is checked field by field against the oldest prediction. The
// wide_addresses register is switched between phases while nothing is in
// flight. Both the sender and the receiver insert random gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pci_bar_size_decoder;

	localparam logic [63:0] FOUR_GB = 64'h1_0000_0000;
	localparam int QUIET_LIMIT = 1000;
	localparam int RANDOM_PER_PHASE = 230;

	logic clk;
	logic arst_n;

	pbsd_probe_if probe ();
	pbsd_result_if result ();
	pbsd_cfg_if cfg ();

	pci_bar_size_decoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.probe(probe),
		.result(result),
		.cfg(cfg)
	);

	pbsd_pkg::probe_t bar_probes[$];
	pbsd_pkg::result_t decoded_q[$];
	pbsd_pkg::result_t want;
	logic wide_bus = 1'b1;
	logic steady = 1'b0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int gap_left = 0;
	int stall_left = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic pbsd_pkg::result_t predict_bar(pbsd_pkg::probe_t p, logic wide_en);
		pbsd_pkg::result_t r;
		logic [31:0] lo;
		logic [31:0] szlo;
		logic [63:0] mask;
		logic [63:0] base;
		logic [63:0] rbk;
		logic [63:0] lowest;
		logic [63:0] span;
		r = '0;
		lo = (p.orig_low == pbsd_pkg::ALL_ONES32) ? 32'd0 : p.orig_low;
		szlo = (p.size_low == pbsd_pkg::ALL_ONES32) ? 32'd0 : p.size_low;
		if (p.rom_probe) begin
			r.resource_kind = pbsd_pkg::KIND_ROM;
			r.rom_enabled = lo[0];
			mask = {32'd0, pbsd_pkg::ROM_ADDR_MASK};
		end else if (lo[0]) begin
			r.resource_kind = pbsd_pkg::KIND_IO;
			r.low_bits = {2'b00, lo[1:0]};
			mask = {32'd0, pbsd_pkg::IO_ADDR_MASK};
		end else begin
			r.resource_kind = pbsd_pkg::KIND_MEM;
			r.low_bits = lo[3:0];
			r.prefetchable = lo[3];
			r.is_64bit = (lo[2:1] == pbsd_pkg::MEM_TYPE_64);
			mask = {32'd0, pbsd_pkg::MEM_ADDR_MASK};
		end
		base = {32'd0, lo} & mask;
		rbk = {32'd0, szlo} & mask;
		if (r.is_64bit) begin
			base[63:32] = p.orig_high;
			rbk[63:32] = p.size_high;
			mask[63:32] = pbsd_pkg::ALL_ONES32;
		end
		lowest = rbk & (~rbk + 64'd1);
		span = lowest;
		if (rbk == 64'd0 || (base == rbk && ((base | (lowest - 64'd1)) & mask) != mask)) begin
			span = 64'd0;
		end
		if (span == 64'd0) begin
			r = '0;
		end else if (r.is_64bit && !wide_en && span > FOUR_GB) begin
			r.unset = 1'b1;
			r.disabled = 1'b1;
		end else if (r.is_64bit && !wide_en && p.orig_high != 32'd0) begin
			r.unset = 1'b1;
			r.region_end = span - 64'd1;
		end else begin
			r.region_start = base;
			r.region_end = base + span - 64'd1;
		end
		return r;
	endfunction

	function automatic pbsd_pkg::probe_t probe_of(logic rom, logic [31:0] lo,
			logic [31:0] szlo, logic [31:0] hi, logic [31:0] szhi);
		pbsd_pkg::probe_t p;
		p.rom_probe = rom;
		p.orig_low = lo;
		p.size_low = szlo;
		p.orig_high = hi;
		p.size_high = szhi;
		return p;
	endfunction

	function automatic pbsd_pkg::probe_t random_probe();
		pbsd_pkg::probe_t p;
		int unsigned pick;
		int unsigned sh;
		logic [63:0] szmask;
		logic [63:0] base;
		logic [3:0] attr;
		p = probe_of(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom);
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			return p;
		end
		p.rom_probe = 1'b0;
		attr = 4'($urandom_range(0, 15));
		if (pick < 30) begin
			sh = $urandom_range(2, 16);
			attr[0] = 1'b1;
			attr[3:2] = 2'b00;
		end else if (pick < 55) begin
			sh = $urandom_range(4, 31);
			attr[0] = 1'b0;
			if (attr[2:1] == pbsd_pkg::MEM_TYPE_64) begin
				attr[2:1] = 2'b00;
			end
		end else if (pick < 80) begin
			sh = $urandom_range(4, 63);
			attr[0] = 1'b0;
			attr[2:1] = pbsd_pkg::MEM_TYPE_64;
		end else begin
			sh = $urandom_range(11, 31);
			p.rom_probe = 1'b1;
			attr[3:1] = 3'b000;
		end
		szmask = ~((64'd1 << sh) - 64'd1);
		base = {$urandom, $urandom} & szmask;
		if ($urandom_range(0, 1)) begin
			base[63:32] = 32'd0;
		end
		p.orig_low = base[31:0] | {28'd0, attr};
		p.size_low = szmask[31:0] | {28'd0, attr};
		if (pick >= 55 && pick < 80) begin
			p.orig_high = base[63:32];
			p.size_high = szmask[63:32];
		end
		case ($urandom_range(0, 19))
			0: p.size_low = pbsd_pkg::ALL_ONES32;
			1: p.orig_low = pbsd_pkg::ALL_ONES32;
			2: p.size_low = p.orig_low;
			3: p.size_low = 32'd0;
			default: ;
		endcase
		return p;
	endfunction

	function automatic int idle_len();
		if ($urandom_range(0, 9) < 7) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
			mismatches++;
		end
	endtask

	task automatic drain();
		while (bar_probes.size() != 0 || probe.valid || decoded_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_wide(logic value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= value;
		do begin
			@(posedge clk);
		end while (!cfg.ready);
		cfg.valid <= 1'b0;
		wide_bus = value;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe.valid <= 1'b0;
			probe.data <= '0;
			gap_left = 0;
		end else begin
			if (probe.valid && probe.ready) begin
				decoded_q.push_back(predict_bar(probe.data, wide_bus));
			end
			if (!probe.valid || probe.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					probe.valid <= 1'b0;
				end else if (bar_probes.size() != 0) begin
					probe.data <= bar_probes.pop_front();
					probe.valid <= 1'b1;
					if (!steady && $urandom_range(0, 2) == 0) begin
						gap_left = idle_len();
					end
				end else begin
					probe.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %h",
						$time, result.data);
					mismatches++;
				end else begin
					want = decoded_q.pop_front();
					check_field("resource_kind", 64'(want.resource_kind),
						64'(result.data.resource_kind));
					check_field("low_bits", 64'(want.low_bits), 64'(result.data.low_bits));
					check_field("prefetchable", 64'(want.prefetchable),
						64'(result.data.prefetchable));
					check_field("is_64bit", 64'(want.is_64bit), 64'(result.data.is_64bit));
					check_field("rom_enabled", 64'(want.rom_enabled),
						64'(result.data.rom_enabled));
					check_field("unset", 64'(want.unset), 64'(result.data.unset));
					check_field("disabled", 64'(want.disabled), 64'(result.data.disabled));
					check_field("region_start", want.region_start, result.data.region_start);
					check_field("region_end", want.region_end, result.data.region_end);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
				if (!steady && $urandom_range(0, 3) == 0) begin
					stall_left = idle_len();
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((probe.valid && probe.ready) || (result.valid && result.ready)
				|| (cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int sent;
		int chunk;
		arst_n <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.data <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		write_wide(1'b0);
		bar_probes.push_back(probe_of(1'b0, 32'h0000_c001, 32'hffff_ffe1, 32'h0, 32'h0));
		bar_probes.push_back(probe_of(1'b0, 32'h0000_0003, 32'hffff_fffd, 32'h0, 32'h0));
		bar_probes.push_back(probe_of(1'b0, 32'h0000_c001, 32'hffff_ffff, 32'h0, 32'h0));
		bar_probes.push_back(probe_of(1'b0, 32'hfe00_0000, 32'hfff0_0000, 32'h0, 32'h0));
		bar_probes.push_back(probe_of(1'b0, 32'he000_0008, 32'hf000_0008, 32'h0, 32'h0));
		bar_probes.push_back(probe_of(1'b0, 32'h000c_0002, 32'hfffe_0002, 32'h0, 32'h0));
		bar_probes.push_back(probe_of(1'b0, 32'h0000_0006, 32'hffff_fff6, 32'h0, 32'h0));
		bar_probes.push_back(probe_of(1'b0, 32'hf000_000c, 32'hffff_c00c,
			32'h0000_0000, 32'hffff_ffff));
		bar_probes.push_back(probe_of(1'b0, 32'hf000_000c, 32'hffff_c00c,
			32'h0000_0010, 32'hffff_ffff));
		bar_probes.push_back(probe_of(1'b0, 32'h0000_000c, 32'h0000_000c,
			32'h0000_0000, 32'hffff_fff0));
		bar_probes.push_back(probe_of(1'b0, 32'h0000_000c, 32'h0000_000c,
			32'h0000_0000, 32'hffff_ffff));
		bar_probes.push_back(probe_of(1'b0, 32'h0000_000c, 32'hfe00_000c,
			32'h0000_0001, 32'hffff_ffff));
		bar_probes.push_back(probe_of(1'b0, 32'hffff_fff4, 32'hffff_fff4,
			32'hffff_ffff, 32'hffff_ffff));
		bar_probes.push_back(probe_of(1'b0, 32'h0000_0004, 32'h0000_0004,
			32'h0000_0000, 32'h0000_0000));
		bar_probes.push_back(probe_of(1'b1, 32'hfeb0_0001, 32'hffff_0001, 32'h0, 32'h0));
		bar_probes.push_back(probe_of(1'b1, 32'h0000_0000, 32'hfffe_0000, 32'h0, 32'h0));
		bar_probes.push_back(probe_of(1'b1, 32'h0000_0001, 32'h0000_07ff, 32'h0, 32'h0));
		bar_probes.push_back(probe_of(1'b0, 32'hffff_ffff, 32'hffff_f000, 32'h0, 32'h0));
		bar_probes.push_back(probe_of(1'b0, 32'h1234_0000, 32'h1234_0000, 32'h0, 32'h0));
		bar_probes.push_back(probe_of(1'b0, 32'hffff_0000, 32'hffff_0000, 32'h0, 32'h0));
		bar_probes.push_back(probe_of(1'b0, 32'h0, 32'h0, 32'h0, 32'h0));
		bar_probes.push_back(probe_of(1'b1, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff));
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			write_wide(phase[0] ? 1'b0 : 1'b1);
			sent = 0;
			while (sent < RANDOM_PER_PHASE) begin
				steady = ($urandom_range(0, 3) == 0);
				chunk = $urandom_range(20, 80);
				for (int i = 0; i < chunk; i++) begin
					bar_probes.push_back(random_probe());
				end
				sent += chunk;
				if ($urandom_range(0, 2) == 0) begin
					drain();
				end else begin
					while (bar_probes.size() > 4) begin
						@(posedge clk);
					end
				end
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && decoded_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
design/pbsd_pkg.sv
design/pbsd_ifs.sv
design/pci_bar_size_decoder.sv
bench/tb_pci_bar_size_decoder.sv
